@@ src/rds_pkg.sv @@
// shared types and constants of the reaction-diffusion stencil block
`default_nettype none
package rds_pkg;
	localparam int C_W    = 24;
	localparam int COEF_W = 16;
	localparam int SIZE_W = 7;
	localparam int IDX_W  = 3;
	localparam int SUM_W  = C_W + 3;

	typedef enum logic [IDX_W-1:0] {
		REG_DIFF,
		REG_GROW,
		REG_CMAX,
		REG_RECIP,
		REG_FLOOR,
		REG_SX,
		REG_SY,
		REG_SZ
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] diff;
		logic [COEF_W-1:0] grow;
		logic [C_W-1:0]    c_max;
		logic [C_W-1:0]    recip;
		logic [COEF_W-1:0] floor_level;
	} coef_t;
endpackage
`default_nettype wire

@@ src/rds_win.sv @@
// window store: one write port, one registered read port
`default_nettype none
module rds_win
	import rds_pkg::*;
#(
	parameter int DEPTH = 8193,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [C_W-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [C_W-1:0]     rdata
);
	logic [C_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/rds_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module rds_div #(
	parameter int NW = 18,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

@@ src/rds_calc.sv @@
// multi-cycle datapath for the logistic growth and diffusion update
`default_nettype none
module rds_calc
	import rds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [C_W-1:0]   c,
	input  wire logic [SUM_W-1:0] sum6,
	input  wire coef_t            coef,
	output logic                  done,
	output logic [C_W-1:0]        result
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_T, ST_G1, ST_G2, ST_G3, ST_P1, ST_P2, ST_R, ST_CL
	} step_t;

	step_t state_q;
	logic  done_q;

	logic [47:0]        m1_c, m1_q, m1_r;
	logic [SUM_W-1:0]   c6;
	logic signed [27:0] sd;
	logic signed [44:0] dprod_c, dprod_q, dprod_r;
	logic signed [28:0] dif_q;
	logic signed [33:0] u_q;
	logic [40:0]        plo_c, plo_q;
	logic signed [41:0] phi_c, phi_q;
	logic signed [58:0] gp_c, gp_q, gp_r;
	logic signed [42:0] g_q;
	logic [35:0]        qlo_c, qlo_q;
	logic signed [39:0] qhi_c, qhi_q;
	logic signed [59:0] gw_c, gw_q, gw_r;
	logic signed [45:0] r_c, r_q, rc;
	logic [C_W-1:0]     res_c, res_q;

	assign m1_c    = c * coef.recip;
	assign m1_r    = m1_q + 48'd32768;
	assign c6      = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
	assign sd      = $signed({1'b0, sum6}) - $signed({1'b0, c6});
	assign dprod_c = $signed({1'b0, coef.diff}) * sd;
	assign dprod_r = dprod_q + 45'sd32768;
	assign plo_c   = c * u_q[16:0];
	assign phi_c   = $signed({1'b0, c}) * $signed(u_q[33:17]);
	assign gp_c    = $signed({phi_q, 17'b0}) + $signed({18'b0, plo_q});
	assign gp_r    = gp_q + 59'sd32768;
	assign qlo_c   = coef.grow * g_q[19:0];
	assign qhi_c   = $signed({1'b0, coef.grow}) * $signed(g_q[42:20]);
	assign gw_c    = $signed({qhi_q, 20'b0}) + $signed({24'b0, qlo_q});
	assign gw_r    = gw_q + 60'sd32768;
	// floor of the rounded sums is the top bits of the two's complement word
	assign r_c     = $signed({22'b0, c}) + $signed({{2{gw_r[59]}}, gw_r[59:16]})
	               + $signed({{17{dif_q[28]}}, dif_q});

	always_comb begin
		if (r_q > $signed({22'b0, coef.c_max})) begin
			rc = $signed({22'b0, coef.c_max});
		end else begin
			rc = r_q;
		end
		if (rc < $signed({30'b0, coef.floor_level})) begin
			res_c = '0;
		end else begin
			res_c = rc[C_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_CL);
			unique case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_T;
				end
				ST_T:  state_q <= ST_G1;
				ST_G1: state_q <= ST_G2;
				ST_G2: state_q <= ST_G3;
				ST_G3: state_q <= ST_P1;
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_R;
				ST_R:  state_q <= ST_CL;
				ST_CL: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			m1_q    <= m1_c;
			dprod_q <= dprod_c;
		end
		if (state_q == ST_T) begin
			u_q   <= 34'sd65536 - $signed({2'b00, m1_r[47:16]});
			dif_q <= dprod_r[44:16];
		end
		if (state_q == ST_G1) begin
			plo_q <= plo_c;
			phi_q <= phi_c;
		end
		if (state_q == ST_G2) begin
			gp_q <= gp_c;
		end
		if (state_q == ST_G3) begin
			g_q <= gp_r[58:16];
		end
		if (state_q == ST_P1) begin
			qlo_q <= qlo_c;
			qhi_q <= qhi_c;
		end
		if (state_q == ST_P2) begin
			gw_q <= gw_c;
		end
		if (state_q == ST_R) begin
			r_q <= r_c;
		end
		if (state_q == ST_CL) begin
			res_q <= res_c;
		end
	end

	assign done   = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

@@ src/reaction_diffusion_stencil_3d.sv @@
// top level of the 3d seven-point reaction-diffusion stencil
//
//  channel   direction  handshake                 payload
//  voxel     in         voxel_valid/voxel_stall   conc_in, padding
//  result    out        result_valid/result_stall conc_out, last
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one item at a time: a voxel that yields no result only passes the check, a boundary
// result also makes 7 reads of the single window port, and an interior result then
// runs the arithmetic unit; after a size write the next result adds two passes of
// the bit-serial divider to find its coordinates.
// reset clears counters and control, loads config defaults; window store not cleared.
// a cfg write holds voxel_stall while plane and volume settle.
// result_stall holds the output register; voxels are taken until a result waits in S_OUT.
`default_nettype none
module reaction_diffusion_stencil_3d
	import rds_pkg::*;
#(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              voxel_valid,
	output logic                   voxel_stall,
	input  wire logic [C_W-1:0]    conc_in,
	input  wire logic              padding,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [C_W-1:0]         conc_out,
	output logic                   last,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [C_W-1:0]    cfg_data
);
	localparam int XSW   = $clog2(MAX_X + 1);
	localparam int YSW   = $clog2(MAX_Y + 1);
	localparam int ZSW   = $clog2(MAX_Z + 1);
	localparam int XW    = $clog2(MAX_X);
	localparam int YW    = $clog2(MAX_Y);
	localparam int ZW    = $clog2(MAX_Z);
	localparam int PLW   = $clog2(MAX_X * MAX_Y + 1);
	localparam int PW    = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
	localparam int PW1   = PW + 1;
	localparam int WIN_D = 2 * MAX_X * MAX_Y + 1;
	localparam int AW    = $clog2(WIN_D);
	localparam int AW1   = AW + 1;
	localparam int DVW   = (XSW > YSW) ? XSW : YSW;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_COORD, S_DIV1, S_DIV2, S_RD, S_RDW, S_CST, S_CWT, S_OUT
	} state_t;

	// window taps in read order, centre first
	typedef enum logic [2:0] {
		TAP_C, TAP_XP, TAP_XM, TAP_YP, TAP_YM, TAP_ZP, TAP_ZM
	} tap_t;

	// configuration
	coef_t             coef_q;
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [1:0]        settle_q;

	// clamped sizes and derived extents
	logic [XSW-1:0] sx_c, sx_q;
	logic [YSW-1:0] sy_c, sy_q;
	logic [ZSW-1:0] sz_c, sz_q;
	logic [PLW-1:0] plane_q;
	logic [PW-1:0]  vol_q;

	// stream control
	state_t         state_q;
	logic [PW-1:0]  in_pos_q, out_pos_q;
	logic [AW-1:0]  in_addr_q, out_addr_q;
	logic [XW-1:0]  ox_q;
	logic [YW-1:0]  oy_q;
	logic [ZW-1:0]  oz_q;
	logic           dirty_q;
	logic [C_W-1:0] item_conc_q;
	logic           item_pad_q;
	tap_t           rd_idx_q;

	// read capture
	logic             rd_v_s1;
	tap_t             rd_tap_s1;
	logic [C_W-1:0]   c_q;
	logic [SUM_W-1:0] sum_q;

	// output register
	logic           out_valid_q;
	logic [C_W-1:0] out_conc_q;
	logic           out_last_q;

	logic           voxel_take;
	logic           out_free;
	logic           boundary;
	logic           vol_end;
	logic [AW-1:0]  off;
	logic [AW1-1:0] up_sum;
	logic [AW-1:0]  rd_addr;
	logic [C_W-1:0] rd_data;
	logic           mem_we;
	logic           div_start;
	logic [PW-1:0]  div_dividend;
	logic [DVW-1:0] div_divisor;
	logic           div_done;
	logic [PW-1:0]  div_quo;
	logic [DVW-1:0] div_rem;
	logic           calc_done;
	logic [C_W-1:0] calc_res;

	assign cfg_ready   = 1'b1;
	assign voxel_stall = (state_q != S_IDLE) || (settle_q != 2'd0);
	assign voxel_take  = voxel_valid && !voxel_stall;
	assign out_free    = !out_valid_q || !result_stall;
	assign vol_end     = ({1'b0, out_pos_q} + PW1'(1)) >= {1'b0, vol_q};

	// sizes saturate into three up to the maximum
	always_comb begin
		if (size_x_q < SIZE_W'(3)) begin
			sx_c = XSW'(3);
		end else if ({25'b0, size_x_q} > 32'(MAX_X)) begin
			sx_c = XSW'(MAX_X);
		end else begin
			sx_c = XSW'(size_x_q);
		end
		if (size_y_q < SIZE_W'(3)) begin
			sy_c = YSW'(3);
		end else if ({25'b0, size_y_q} > 32'(MAX_Y)) begin
			sy_c = YSW'(MAX_Y);
		end else begin
			sy_c = YSW'(size_y_q);
		end
		if (size_z_q < SIZE_W'(3)) begin
			sz_c = ZSW'(3);
		end else if ({25'b0, size_z_q} > 32'(MAX_Z)) begin
			sz_c = ZSW'(MAX_Z);
		end else begin
			sz_c = ZSW'(size_z_q);
		end
	end

	// a voxel on any face of the volume passes through unchanged
	assign boundary = (ox_q == '0) || (XSW'(ox_q) == sx_q - XSW'(1))
	               || (oy_q == '0) || (YSW'(oy_q) == sy_q - YSW'(1))
	               || (oz_q == '0) || (ZSW'(oz_q) == sz_q - ZSW'(1));

	// circular window address of the current tap
	always_comb begin
		unique case (rd_idx_q)
			TAP_C:          off = '0;
			TAP_XP, TAP_XM: off = AW'(1);
			TAP_YP, TAP_YM: off = AW'(sx_q);
			TAP_ZP, TAP_ZM: off = AW'(plane_q);
			default:        off = '0;
		endcase
		up_sum = {1'b0, out_addr_q} + {1'b0, off};
		if (rd_idx_q == TAP_XM || rd_idx_q == TAP_YM || rd_idx_q == TAP_ZM) begin
			if (out_addr_q >= off) begin
				rd_addr = out_addr_q - off;
			end else begin
				rd_addr = AW'(AW1'(WIN_D) - {1'b0, off} + {1'b0, out_addr_q});
			end
		end else if (up_sum >= AW1'(WIN_D)) begin
			rd_addr = AW'(up_sum - AW1'(WIN_D));
		end else begin
			rd_addr = up_sum[AW-1:0];
		end
	end

	assign mem_we = (state_q == S_CHK) && (out_pos_q < vol_q) && (in_pos_q < vol_q)
	             && !item_pad_q;

	// shared divider: position by row length, then row index by plane height
	assign div_start    = (state_q == S_COORD && dirty_q) || (state_q == S_DIV1 && div_done);
	assign div_dividend = (state_q == S_DIV1) ? div_quo : out_pos_q;
	assign div_divisor  = (state_q == S_DIV1) ? DVW'(sy_q) : DVW'(sx_q);

	rds_win #(
		.DEPTH (WIN_D)
	) u_win (
		.clk   (clk),
		.we    (mem_we),
		.waddr (in_addr_q),
		.wdata (item_conc_q),
		.re    (state_q == S_RD),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rds_div #(
		.NW (PW),
		.DW (DVW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	rds_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_CST),
		.c      (c_q),
		.sum6   (sum_q),
		.coef   (coef_q),
		.done   (calc_done),
		.result (calc_res)
	);

	// configuration registers and derived extents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.diff        <= '0;
			coef_q.grow        <= '0;
			coef_q.c_max       <= C_W'(65536);
			coef_q.recip       <= C_W'(65536);
			coef_q.floor_level <= COEF_W'(1);
			size_x_q           <= SIZE_W'(64);
			size_y_q           <= SIZE_W'(64);
			size_z_q           <= SIZE_W'(64);
			settle_q           <= 2'd3;
			sx_q               <= '0;
			sy_q               <= '0;
			sz_q               <= '0;
			plane_q            <= '0;
			vol_q              <= '0;
		end else begin
			sx_q    <= sx_c;
			sy_q    <= sy_c;
			sz_q    <= sz_c;
			plane_q <= PLW'({{(PLW-XSW){1'b0}}, sx_q} * {{(PLW-YSW){1'b0}}, sy_q});
			vol_q   <= PW'({{(PW-PLW){1'b0}}, plane_q} * {{(PW-ZSW){1'b0}}, sz_q});
			if (settle_q != 2'd0 && !(cfg_valid && cfg_ready)) begin
				settle_q <= settle_q - 2'd1;
			end
			if (cfg_valid && cfg_ready) begin
				settle_q <= 2'd3;
				unique case (cfg_reg_t'(cfg_index))
					REG_DIFF:  coef_q.diff        <= cfg_data[COEF_W-1:0];
					REG_GROW:  coef_q.grow        <= cfg_data[COEF_W-1:0];
					REG_CMAX:  coef_q.c_max       <= cfg_data;
					REG_RECIP: coef_q.recip       <= cfg_data;
					REG_FLOOR: coef_q.floor_level <= cfg_data[COEF_W-1:0];
					REG_SX:    size_x_q           <= cfg_data[SIZE_W-1:0];
					REG_SY:    size_y_q           <= cfg_data[SIZE_W-1:0];
					REG_SZ:    size_z_q           <= cfg_data[SIZE_W-1:0];
				endcase
			end
		end
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_pos_q    <= '0;
			out_pos_q   <= '0;
			in_addr_q   <= '0;
			out_addr_q  <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			oz_q        <= '0;
			dirty_q     <= 1'b0;
			rd_idx_q    <= TAP_C;
			out_valid_q <= 1'b0;
		end else begin
			// the output state refills the register itself
			if (out_valid_q && !result_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			// a new size may leave the coordinates out of step with the position
			if (cfg_valid && cfg_ready && (cfg_reg_t'(cfg_index) == REG_SX
				|| cfg_reg_t'(cfg_index) == REG_SY || cfg_reg_t'(cfg_index) == REG_SZ)) begin
				dirty_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: if (voxel_take) begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (out_pos_q >= vol_q) begin
						// volume shrank under the counters: start over
						in_pos_q   <= '0;
						out_pos_q  <= '0;
						in_addr_q  <= '0;
						out_addr_q <= '0;
						ox_q       <= '0;
						oy_q       <= '0;
						oz_q       <= '0;
						dirty_q    <= 1'b0;
					end else if (in_pos_q < vol_q) begin
						if (item_pad_q) begin
							state_q <= S_IDLE;
						end else begin
							in_pos_q <= in_pos_q + PW'(1);
							if (in_addr_q == AW'(WIN_D - 1)) begin
								in_addr_q <= '0;
							end else begin
								in_addr_q <= in_addr_q + AW'(1);
							end
							// result leaves once its upper-plane neighbour is in
							if ({1'b0, in_pos_q} < ({1'b0, out_pos_q} + PW1'(plane_q))) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_COORD;
							end
						end
					end else begin
						// flush item after the whole volume has arrived
						state_q <= S_COORD;
					end
				end
				S_COORD: begin
					rd_idx_q <= TAP_C;
					if (dirty_q) begin
						state_q <= S_DIV1;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DIV1: if (div_done) begin
					ox_q    <= XW'(div_rem);
					state_q <= S_DIV2;
				end
				S_DIV2: if (div_done) begin
					oy_q    <= YW'(div_rem);
					oz_q    <= ZW'(div_quo);
					dirty_q <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: begin
					if (rd_idx_q == TAP_ZM) begin
						state_q <= S_RDW;
					end else begin
						rd_idx_q <= tap_t'(rd_idx_q + 3'd1);
					end
				end
				S_RDW: begin
					if (boundary) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_CST;
					end
				end
				S_CST: state_q <= S_CWT;
				S_CWT: if (calc_done) begin
					state_q <= S_OUT;
				end
				S_OUT: if (out_free) begin
					out_valid_q <= 1'b1;
					out_conc_q  <= boundary ? c_q : calc_res;
					out_last_q  <= (out_pos_q == vol_q - PW'(1));
					state_q     <= S_IDLE;
					if (vol_end) begin
						in_pos_q   <= '0;
						out_pos_q  <= '0;
						in_addr_q  <= '0;
						out_addr_q <= '0;
						ox_q       <= '0;
						oy_q       <= '0;
						oz_q       <= '0;
					end else begin
						out_pos_q <= out_pos_q + PW'(1);
						if (out_addr_q == AW'(WIN_D - 1)) begin
							out_addr_q <= '0;
						end else begin
							out_addr_q <= out_addr_q + AW'(1);
						end
						// raster order: x fastest, then y, then z
						if (XSW'(ox_q) == sx_q - XSW'(1)) begin
							ox_q <= '0;
							if (YSW'(oy_q) == sy_q - YSW'(1)) begin
								oy_q <= '0;
								oz_q <= oz_q + ZW'(1);
							end else begin
								oy_q <= oy_q + YW'(1);
							end
						end else begin
							ox_q <= ox_q + XW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (voxel_take) begin
			item_conc_q <= conc_in;
			item_pad_q  <= padding;
		end
	end

	// gather centre value and neighbour sum from the window reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_RD);
		end
	end

	always_ff @(posedge clk) begin
		rd_tap_s1 <= rd_idx_q;
		if (rd_v_s1) begin
			if (rd_tap_s1 == TAP_C) begin
				c_q   <= rd_data;
				sum_q <= '0;
			end else begin
				sum_q <= sum_q + SUM_W'(rd_data);
			end
		end
	end

	assign result_valid = out_valid_q;
	assign conc_out     = out_conc_q;
	assign last         = out_last_q;
endmodule
`default_nettype wire

@@ src/rds_check.sv @@
// port checker for the stencil top level and its bind
`default_nettype none
module rds_check
	import rds_pkg::*;
(
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           voxel_valid,
	input wire logic           voxel_stall,
	input wire logic           result_valid,
	input wire logic           result_stall,
	input wire logic [C_W-1:0] conc_out,
	input wire logic           last,
	input wire logic           cfg_valid,
	input wire logic           cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(conc_out) && $stable(last))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		voxel_valid && !voxel_stall |=> voxel_stall)
		else $error("voxel taken while previous one still in work");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> voxel_stall)
		else $error("voxel taken right after config write");
endmodule

bind reaction_diffusion_stencil_3d rds_check u_rds_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.voxel_valid  (voxel_valid),
	.voxel_stall  (voxel_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.conc_out     (conc_out),
	.last         (last),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
`default_nettype wire
